// ----- sv/civil_date_to_epoch_days_assert.svh -----
// Assertion macros used by the top level of the civil date converter.
// Depends on nothing; define NO_ASSERTIONS to compile the checks away.
`ifndef CIVIL_DATE_TO_EPOCH_DAYS_ASSERT_SVH
`define CIVIL_DATE_TO_EPOCH_DAYS_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked property, switched off while the reset is asserted.
`define CDTE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cdte assertion failed");
// Checked property that also holds during reset.
`define CDTE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cdte assertion failed");
`else
`define CDTE_ASSERT(lbl, clk, rstn, prop)
`define CDTE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- sv/cdte_pkg.sv -----
// Package of the civil date converter: field widths, codes, date tables
// and the calendar helper functions. Depends on nothing.
`default_nettype none

package cdte_pkg;

  // Field widths.
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DaysW  = 24;
  localparam int unsigned OrderW = 2;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRefYear  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRefMonth = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRefDay   = 2'd2;

  // Comparison codes.
  localparam logic signed [OrderW-1:0] OrdBefore = -2'sd1;
  localparam logic signed [OrderW-1:0] OrdEqual  = 2'sd0;
  localparam logic signed [OrderW-1:0] OrdAfter  = 2'sd1;

  // Reset value of the reference date.
  localparam logic [YearW-1:0]  RefYearRst  = 14'd1970;
  localparam logic [MonthW-1:0] RefMonthRst = 4'd1;
  localparam logic [DayW-1:0]   RefDayRst   = 5'd1;

  // Day number of 1970-01-01 counted from 0000-03-01, plus one for the
  // day-of-month that starts at 1.
  localparam logic [DaysW-1:0] EpochBias = 24'd719469;

  // Reciprocal of 100: floor(x / 100) == (x * Div100Mul) >> Div100Shift
  // for every 14-bit x.
  localparam int unsigned Div100Shift = 20;
  localparam int unsigned Div100ProdW = YearW + Div100Shift - 6;
  localparam logic [Div100ProdW-1:0] Div100Mul = 28'd10486;
  localparam logic [6:0] Hundred = 7'd100;

  typedef logic [7:0] q100_t;

  // Reference date as held by the configuration registers.
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic              valid;
  } ref_date_t;

  // Result of the date check and day count.
  typedef struct packed {
    logic                    valid;
    logic signed [DaysW-1:0] days;
  } calc_res_t;

  // Quotient by 100 through the reciprocal multiply.
  function automatic q100_t div100(input logic [YearW-1:0] x);
    logic [Div100ProdW-1:0] prod;
    prod = Div100Mul * Div100ProdW'(x);
    return prod[Div100ProdW-1:Div100Shift];
  endfunction

  // Gregorian leap year rule.
  function automatic logic is_leap(input logic [YearW-1:0] y);
    q100_t      q;
    logic [YearW-1:0] back;
    logic       cent;
    q    = div100(y);
    back = YearW'(q * Hundred);
    cent = (back == y);
    return cent ? (q[1:0] == 2'b00) : (y[1:0] == 2'b00);
  endfunction

  // Length of a month in a common year; zero for month codes out of range.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Full date check.
  function automatic logic date_ok(input logic [YearW-1:0] y,
                                   input logic [MonthW-1:0] m,
                                   input logic [DayW-1:0] d);
    logic [DayW-1:0] len;
    len = month_len(m);
    if ((m == 4'd2) && is_leap(y)) begin
      len = 5'd29;
    end
    return (y != '0) && (m >= 4'd1) && (m <= 4'd12) && (d >= 5'd1) && (d <= len);
  endfunction

  // Days from March 1 to the first of the month, in a year that starts
  // in March (January and February close the previous year).
  function automatic logic [8:0] doy_base(input logic [MonthW-1:0] m);
    logic [8:0] base;
    case (m)
      4'd3:    base = 9'd0;
      4'd4:    base = 9'd31;
      4'd5:    base = 9'd61;
      4'd6:    base = 9'd92;
      4'd7:    base = 9'd122;
      4'd8:    base = 9'd153;
      4'd9:    base = 9'd184;
      4'd10:   base = 9'd214;
      4'd11:   base = 9'd245;
      4'd12:   base = 9'd275;
      4'd1:    base = 9'd306;
      4'd2:    base = 9'd337;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

// ----- sv/civil_date_to_epoch_days.sv -----
// Top level of the civil date converter: input register, date logic,
// reference comparison and result register. Depends on cdte_pkg,
// cdte_cfg, cdte_calc and civil_date_to_epoch_days_assert.svh.
//
// Usage: a date transfer happens at a rising edge with start high and busy
// low. busy stays low, so a new date can be taken at every edge. Each date
// gives one result: done_o is high for exactly one cycle, after the input
// register and then the result register have taken the date, together with
// date_valid_o, epoch_days_o, order_o and is_future_o; the result ports
// hold their value between strobes. The input register feeds the
// year-scaling multiply, the leap-day quotient and the adder, which feed
// the result register. Throughput is one date per cycle.
// The receiver takes each result in its strobe cycle and cannot stall.
// The reference date is written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i; a write lands at its edge and index three is ignored.
// Reset clears the pipeline strobes and loads the reference 1970-01-01.
`default_nettype none

`include "civil_date_to_epoch_days_assert.svh"

module civil_date_to_epoch_days (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [cdte_pkg::YearW-1:0]          year_i,
  input  logic [cdte_pkg::MonthW-1:0]         month_i,
  input  logic [cdte_pkg::DayW-1:0]           day_i,
  input  logic                                cfg_we_i,
  input  logic [cdte_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [cdte_pkg::YearW-1:0]          cfg_wdata_i,
  output logic                                done_o,
  output logic                                date_valid_o,
  output logic signed [cdte_pkg::DaysW-1:0]   epoch_days_o,
  output logic signed [cdte_pkg::OrderW-1:0]  order_o,
  output logic                                is_future_o
);
  import cdte_pkg::*;

  ref_date_t ref_date;
  calc_res_t calc;

  logic              vld_q;
  logic [YearW-1:0]  year_q;
  logic [MonthW-1:0] month_q;
  logic [DayW-1:0]   day_q;

  logic signed [OrderW-1:0] order_d;
  logic                     done_q;
  logic                     date_valid_q;
  logic signed [DaysW-1:0]  epoch_days_q;
  logic signed [OrderW-1:0] order_q;
  logic                     is_future_q;

  // Every stage moves on each cycle, so a transfer is never refused.
  assign busy = 1'b0;

  cdte_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ref_o       (ref_date)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      year_q  <= year_i;
      month_q <= month_i;
      day_q   <= day_i;
    end
  end

  cdte_calc u_calc (
    .year_i  (year_q),
    .month_i (month_q),
    .day_i   (day_q),
    .res_o   (calc)
  );

  // Year, month and day packed together compare in calendar order.
  always_comb begin
    order_d = OrdEqual;
    if (calc.valid && ref_date.valid) begin
      if ({year_q, month_q, day_q} < {ref_date.year, ref_date.month, ref_date.day}) begin
        order_d = OrdBefore;
      end else if ({year_q, month_q, day_q} >
                   {ref_date.year, ref_date.month, ref_date.day}) begin
        order_d = OrdAfter;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      date_valid_q <= calc.valid;
      epoch_days_q <= calc.days;
      order_q      <= order_d;
      is_future_q  <= (order_d == OrdAfter);
    end
  end

  assign done_o       = done_q;
  assign date_valid_o = date_valid_q;
  assign epoch_days_o = epoch_days_q;
  assign order_o      = order_q;
  assign is_future_o  = is_future_q;

  // Each transfer gives exactly one result, through the input register and the result register.
  `CDTE_ASSERT(a_latency, clk_i, rst_ni, (start && !busy) |=> ##1 done_o)
  `CDTE_ASSERT(a_no_spurious, clk_i, rst_ni, done_o |-> $past(start && !busy, 2))
  // An invalid date never reports a day count or an ordering.
  `CDTE_ASSERT(a_invalid_clean, clk_i, rst_ni,
    (done_o && !date_valid_o) |-> (epoch_days_o == '0 && order_o == OrdEqual && !is_future_o))
  // No result strobe while reset is held.
  `CDTE_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !done_o)

endmodule

`default_nettype wire

// ----- sv/cdte_cfg.sv -----
// Reference date registers of the civil date converter, with the
// reference validity kept alongside them. Depends on cdte_pkg.
`default_nettype none

module cdte_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cdte_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cdte_pkg::YearW-1:0]   cfg_wdata_i,
  output cdte_pkg::ref_date_t          ref_o
);
  import cdte_pkg::*;

  ref_date_t ref_d, ref_q;

  // Register write decode; the validity follows the new value.
  always_comb begin
    ref_d = ref_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRefYear:  ref_d.year  = cfg_wdata_i;
        CfgRefMonth: ref_d.month = cfg_wdata_i[MonthW-1:0];
        CfgRefDay:   ref_d.day   = cfg_wdata_i[DayW-1:0];
        default:     ref_d = ref_q;
      endcase
    end
    ref_d.valid = date_ok(ref_d.year, ref_d.month, ref_d.day);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q.year  <= RefYearRst;
      ref_q.month <= RefMonthRst;
      ref_q.day   <= RefDayRst;
      ref_q.valid <= 1'b1;
    end else begin
      ref_q <= ref_d;
    end
  end

  assign ref_o = ref_q;

endmodule

`default_nettype wire

// ----- sv/cdte_calc.sv -----
// Combinational date check and day count of the civil date converter.
// Depends on cdte_pkg.
`default_nettype none

module cdte_calc (
  input  logic [cdte_pkg::YearW-1:0]  year_i,
  input  logic [cdte_pkg::MonthW-1:0] month_i,
  input  logic [cdte_pkg::DayW-1:0]   day_i,
  output cdte_pkg::calc_res_t         res_o
);
  import cdte_pkg::*;

  logic [YearW-1:0] ys;
  q100_t            q100;
  logic [DaysW-1:0] pos;
  logic [DaysW-1:0] sum;

  // Years counted from March, so the leap day ends the year.
  assign ys   = year_i - YearW'(month_i <= 4'd2);
  assign q100 = div100(ys);

  // 365 days a year plus the leap days of the 4/100/400 rule; the quotient
  // by 400 is the quotient by 100 shifted down by two.
  always_comb begin
    pos = DaysW'(ys) * DaysW'(365);
    sum = pos + DaysW'(ys >> 2) + DaysW'(q100 >> 2) + DaysW'(doy_base(month_i))
        + DaysW'(day_i) - DaysW'(q100) - EpochBias;
  end

  always_comb begin
    res_o.valid = date_ok(year_i, month_i, day_i);
    res_o.days  = res_o.valid ? $signed(sum) : '0;
  end

endmodule

`default_nettype wire
